>>> hw/rtl/dnv_pkg.sv
// dnv_pkg: shared types, constants and byte classifiers for the domain name validator
// no dependencies; used by dnv_in_stage, dnv_name_state and domain_name_validator under hw/rtl
package dnv_pkg;

  // special bytes
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_HYPHEN = 8'h2D;

  // counter widths and saturation points
  localparam int unsigned NAME_LEN_W  = 8;
  localparam int unsigned LABEL_LEN_W = 7;

  // register reset values
  localparam logic [5:0] MAX_LABEL_RST = 6'd63;
  localparam logic [7:0] MAX_NAME_RST  = 8'd253;
  localparam logic [5:0] MIN_TOP_RST   = 6'd2;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_MAX_LABEL = 2'd0,
    REG_MAX_NAME  = 2'd1,
    REG_MIN_TOP   = 2'd2
  } reg_idx_t;

  // one input beat
  typedef struct packed {
    logic [7:0] character;
    logic       last_char;
  } beat_t;

  // configured limits
  typedef struct packed {
    logic [5:0] max_label;
    logic [7:0] max_name;
    logic [5:0] min_top;
  } limits_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
  endfunction

endpackage

>>> hw/rtl/dnv_in_stage.sv
// dnv_in_stage: input register that holds one accepted beat until it is consumed
// depends on dnv_pkg (beat_t)
module dnv_in_stage (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  dnv_pkg::beat_t in_beat,
  input  logic           advance,
  output logic           s1_valid,
  output dnv_pkg::beat_t s1_beat
);

  logic           valid_r;
  logic           valid_nxt;
  dnv_pkg::beat_t beat_r;

  // free when empty or when the held beat moves on this cycle
  assign in_ready  = !valid_r || advance;
  assign valid_nxt = in_ready ? in_valid : valid_r;

  // valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload capture
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      beat_r <= in_beat;
    end
  end

  assign s1_valid = valid_r;
  assign s1_beat  = beat_r;

endmodule

>>> hw/rtl/dnv_name_state.sv
// dnv_name_state: per-name counters and flags, one update per consumed beat, plus the verdict
// depends on dnv_pkg (beat_t, limits_t, byte classifiers)
module dnv_name_state (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             advance,
  input  dnv_pkg::beat_t   beat,
  input  dnv_pkg::limits_t limits,
  output logic             verdict
);

  localparam logic [dnv_pkg::NAME_LEN_W-1:0]  NAME_SAT  = '1;
  localparam logic [dnv_pkg::LABEL_LEN_W-1:0] LABEL_SAT = '1;

  logic [dnv_pkg::NAME_LEN_W-1:0]  name_len_r, name_len_nxt, name_inc;
  logic [dnv_pkg::LABEL_LEN_W-1:0] label_len_r, label_len_nxt, label_inc;
  logic seen_dot_r, seen_dot_nxt;
  logic prev_dot_r, prev_dot_nxt;
  logic prev_hyph_r, prev_hyph_nxt;
  logic all_digits_r, all_digits_nxt;
  logic failed_r, failed_nxt;
  logic is_dot, is_hyph, is_dig, is_let;

  // byte class
  assign is_dot  = (beat.character == dnv_pkg::CH_DOT);
  assign is_hyph = (beat.character == dnv_pkg::CH_HYPHEN);
  assign is_dig  = dnv_pkg::is_digit(beat.character);
  assign is_let  = dnv_pkg::is_letter(beat.character);

  // saturating counts
  assign name_inc  = (name_len_r == NAME_SAT) ? name_len_r : name_len_r + 1'b1;
  assign label_inc = (label_len_r == LABEL_SAT) ? label_len_r : label_len_r + 1'b1;

  // next state for this beat
  always_comb begin
    name_len_nxt   = name_inc;
    label_len_nxt  = label_len_r;
    seen_dot_nxt   = seen_dot_r;
    prev_dot_nxt   = prev_dot_r;
    prev_hyph_nxt  = prev_hyph_r;
    all_digits_nxt = all_digits_r;
    failed_nxt     = failed_r || (name_inc > limits.max_name);
    if (is_dot) begin
      // a dot closes a label that must be non-empty and not end in a hyphen
      if (prev_dot_r || prev_hyph_r) begin
        failed_nxt = 1'b1;
      end
      seen_dot_nxt   = 1'b1;
      prev_dot_nxt   = 1'b1;
      prev_hyph_nxt  = 1'b0;
      label_len_nxt  = '0;
      all_digits_nxt = 1'b1;
    end else begin
      if (is_hyph) begin
        if (prev_dot_r) begin
          failed_nxt = 1'b1;
        end
      end else if (!is_dig && !is_let) begin
        failed_nxt = 1'b1;
      end
      if (!is_dig) begin
        all_digits_nxt = 1'b0;
      end
      label_len_nxt = label_inc;
      if (label_inc > {1'b0, limits.max_label}) begin
        failed_nxt = 1'b1;
      end
      prev_dot_nxt  = 1'b0;
      prev_hyph_nxt = is_hyph;
    end
  end

  // verdict on the final beat
  assign verdict = !failed_nxt && seen_dot_nxt && !prev_dot_nxt && !prev_hyph_nxt &&
                   (label_len_nxt >= {1'b0, limits.min_top}) && !all_digits_nxt;

  // state registers, cleared after every final beat
  always_ff @(posedge clk) begin
    if (!rst_n || (advance && beat.last_char)) begin
      name_len_r   <= '0;
      label_len_r  <= '0;
      seen_dot_r   <= 1'b0;
      prev_dot_r   <= 1'b1;
      prev_hyph_r  <= 1'b0;
      all_digits_r <= 1'b1;
      failed_r     <= 1'b0;
    end else if (advance) begin
      name_len_r   <= name_len_nxt;
      label_len_r  <= label_len_nxt;
      seen_dot_r   <= seen_dot_nxt;
      prev_dot_r   <= prev_dot_nxt;
      prev_hyph_r  <= prev_hyph_nxt;
      all_digits_r <= all_digits_nxt;
      failed_r     <= failed_nxt;
    end
  end

  // state is back at start after a final beat
  assert property (@(posedge clk) disable iff (!rst_n)
    advance && beat.last_char |=> (name_len_r == '0) && prev_dot_r && !failed_r)
    else $error("name state not cleared after final beat");

  // a label never counts more bytes than the whole name
  assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, label_len_r} <= name_len_r)
    else $error("label length exceeds name length");

  // right after a dot the current label is empty
  assert property (@(posedge clk) disable iff (!rst_n)
    prev_dot_r && (name_len_r != '0) |-> (label_len_r == '0) && seen_dot_r)
    else $error("label length nonzero after dot");

endmodule

>>> hw/rtl/dnv_out_stage.sv
// dnv_out_stage: result register holding one verdict until the sink takes it
// no package dependencies
module dnv_out_stage (
  input  logic clk,
  input  logic rst_n,
  input  logic load,
  input  logic verdict,
  output logic can_load,
  output logic out_valid,
  input  logic out_ready,
  output logic out_name_valid
);

  logic valid_r, valid_nxt;
  logic result_r;

  // room when empty or when the held result leaves this cycle
  assign can_load  = !valid_r || out_ready;
  assign valid_nxt = load || (valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (load) begin
      result_r <= verdict;
    end
  end

  assign out_valid      = valid_r;
  assign out_name_valid = result_r;

endmodule

>>> hw/rtl/domain_name_validator.sv
// domain_name_validator: streaming hostname syntax checker, one byte per beat
// depends on dnv_pkg, dnv_in_stage, dnv_name_state, dnv_out_stage
// path: bytes sit in the input register, final verdicts in the result register
// throughput: one byte per cycle unless a final byte stalls on a full result register
// the input register and result register decouple the two channels
// reset (synchronous, rst_n low): channels empty, name state at start, limits 63/253/2
module domain_name_validator (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_character,
  input  logic       in_last_char,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_name_valid,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data
);

  dnv_pkg::beat_t   in_beat, s1_beat;
  dnv_pkg::limits_t limits_r;
  logic             s1_valid, advance, can_load, verdict;

  assign in_beat.character = in_character;
  assign in_beat.last_char = in_last_char;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limits_r.max_label <= dnv_pkg::MAX_LABEL_RST;
      limits_r.max_name  <= dnv_pkg::MAX_NAME_RST;
      limits_r.min_top   <= dnv_pkg::MIN_TOP_RST;
    end else if (cfg_we) begin
      unique case (dnv_pkg::reg_idx_t'(cfg_index))
        dnv_pkg::REG_MAX_LABEL: limits_r.max_label <= cfg_data[5:0];
        dnv_pkg::REG_MAX_NAME:  limits_r.max_name  <= cfg_data;
        dnv_pkg::REG_MIN_TOP:   limits_r.min_top   <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  // a held beat moves on unless it is final and a full result register is stalled
  assign advance = s1_valid && (!s1_beat.last_char || can_load);

  dnv_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_beat  (in_beat),
    .advance  (advance),
    .s1_valid (s1_valid),
    .s1_beat  (s1_beat)
  );

  dnv_name_state u_state (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .beat    (s1_beat),
    .limits  (limits_r),
    .verdict (verdict)
  );

  dnv_out_stage u_out (
    .clk            (clk),
    .rst_n          (rst_n),
    .load           (advance && s1_beat.last_char),
    .verdict        (verdict),
    .can_load       (can_load),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_name_valid (out_name_valid)
  );

  // a new result appears only after a final beat was consumed
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(advance && s1_beat.last_char))
    else $error("result without a final beat");

  // a final beat is never consumed into a full, stalled result register
  assert property (@(posedge clk) disable iff (!rst_n)
    advance && s1_beat.last_char |-> !out_valid || out_ready)
    else $error("result overwritten");

  // a stalled result stays until the sink takes it
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("pending result dropped");

endmodule

>>> tb/tb_domain_name_validator.sv
// tb_domain_name_validator: self-checking testbench for the streaming hostname checker
// depends on dnv_pkg and domain_name_validator; a class predicts each name's verdict
// and checks the result beats in order, while plain tasks drive bytes and limits
module tb_domain_name_validator;

  // index that decodes to no register
  localparam logic [1:0] REG_NONE = 2'd3;
  // printable anchors for building names
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam int BYTES_PER_SETTING = 80;

  typedef logic [7:0] name_t[$];

  // predicts hostname verdicts and checks them against the result beats
  class hostname_checker;
    logic [5:0] max_label;
    logic [7:0] max_name;
    logic [5:0] min_top;
    logic [7:0] name_len;
    logic [6:0] label_len;
    bit         seen_dot;
    bit         prev_dot;
    bit         prev_hyphen;
    bit         all_digits;
    bit         failed;
    bit         verdicts_due[$];
    int         mismatches;
    int         names_checked;
    int         names_valid;

    function new();
      max_label     = dnv_pkg::MAX_LABEL_RST;
      max_name      = dnv_pkg::MAX_NAME_RST;
      min_top       = dnv_pkg::MIN_TOP_RST;
      mismatches    = 0;
      names_checked = 0;
      names_valid   = 0;
      start_name();
    endfunction

    function void start_name();
      name_len    = '0;
      label_len   = '0;
      seen_dot    = 1'b0;
      prev_dot    = 1'b1;
      prev_hyphen = 1'b0;
      all_digits  = 1'b1;
      failed      = 1'b0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [7:0] data);
      case (idx)
        dnv_pkg::REG_MAX_LABEL: max_label = data[5:0];
        dnv_pkg::REG_MAX_NAME:  max_name  = data;
        dnv_pkg::REG_MIN_TOP:   min_top   = data[5:0];
        default: ;
      endcase
    endfunction

    function bit digit(logic [7:0] c);
      return c >= 8'h30 && c <= 8'h39;
    endfunction

    function bit letter(logic [7:0] c);
      return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
    endfunction

    function void note_byte(logic [7:0] c, logic last);
      bit hyphen;
      hyphen = (c == dnv_pkg::CH_HYPHEN);
      if (name_len != 8'hFF) name_len++;
      if (name_len > max_name) failed = 1'b1;
      if (c == dnv_pkg::CH_DOT) begin
        // a dot closes a label: no empty label, no trailing hyphen
        if (prev_dot || prev_hyphen) failed = 1'b1;
        seen_dot    = 1'b1;
        prev_dot    = 1'b1;
        prev_hyphen = 1'b0;
        label_len   = '0;
        all_digits  = 1'b1;
      end else begin
        if (hyphen) begin
          if (prev_dot) failed = 1'b1;
        end else if (!digit(c) && !letter(c)) begin
          failed = 1'b1;
        end
        if (!digit(c)) all_digits = 1'b0;
        if (label_len != 7'h7F) label_len++;
        if (label_len > max_label) failed = 1'b1;
        prev_dot    = 1'b0;
        prev_hyphen = hyphen;
      end
      // verdict only on the closing byte
      if (last) begin
        verdicts_due.push_back(!failed && seen_dot && !prev_dot && !prev_hyphen &&
                               label_len >= min_top && !all_digits);
        start_name();
      end
    endfunction

    function void check_verdict(logic actual);
      bit want;
      if (verdicts_due.size() == 0) begin
        $error("name_valid: no verdict pending, got %0b", actual);
        mismatches++;
        return;
      end
      want = verdicts_due.pop_front();
      names_checked++;
      if (want) names_valid++;
      if (actual !== want) begin
        $error("name_valid: expected %0b, got %0b", want, actual);
        mismatches++;
      end
    endfunction

    function int pending();
      return verdicts_due.size();
    endfunction
  endclass

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] in_character;
  logic       in_last_char;
  logic       out_valid;
  logic       out_ready;
  logic       out_name_valid;
  logic       cfg_we;
  logic [1:0] cfg_index;
  logic [7:0] cfg_data;

  hostname_checker board;
  int bytes_sent;
  int settings_used;
  int in_calm;
  int out_calm;

  domain_name_validator DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_character  (in_character),
    .in_last_char  (in_last_char),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_name_valid(out_name_valid),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // clock
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // wait per beat, with occasional back-to-back stretches
  function automatic int draw_wait(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      calm = $urandom_range(16, 64);
      return 0;
    end
    return $urandom_range(0, 8);
  endfunction

  function automatic logic [7:0] alnum();
    int r;
    r = $urandom_range(0, 61);
    if (r < 26) return 8'(CH_LOWER_A + r);
    if (r < 52) return 8'(CH_UPPER_A + r - 26);
    return 8'(CH_ZERO + r - 52);
  endfunction

  function automatic name_t text(string s);
    name_t q;
    for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
    return q;
  endfunction

  function automatic string rep(string ch, int n);
    string s;
    s = "";
    for (int i = 0; i < n; i++) s = {s, ch};
    return s;
  endfunction

  // well-formed host with random content, sometimes damaged, sometimes plain noise
  function automatic name_t random_name();
    name_t q;
    int nlab;
    int len;
    int pos;
    if ($urandom_range(0, 9) == 0) begin
      len = $urandom_range(1, 12);
      for (int i = 0; i < len; i++) q.push_back(8'($urandom_range(0, 255)));
      return q;
    end
    nlab = $urandom_range(2, 4);
    for (int l = 0; l < nlab; l++) begin
      if (l > 0) q.push_back(dnv_pkg::CH_DOT);
      len = ($urandom_range(0, 11) == 0) ? $urandom_range(1, 66) : $urandom_range(1, 6);
      for (int i = 0; i < len; i++) begin
        if (l == nlab - 1 && i == 0)
          q.push_back(8'(CH_LOWER_A + $urandom_range(0, 25)));
        else if (i > 0 && i < len - 1 && $urandom_range(0, 5) == 0)
          q.push_back(dnv_pkg::CH_HYPHEN);
        else
          q.push_back(alnum());
      end
    end
    if ($urandom_range(0, 2) == 0) begin
      pos = $urandom_range(0, q.size() - 1);
      case ($urandom_range(0, 5))
        0: q[pos] = 8'($urandom_range(0, 255));
        1: q[pos] = dnv_pkg::CH_DOT;
        2: q[pos] = dnv_pkg::CH_HYPHEN;
        3: q.push_front(dnv_pkg::CH_DOT);
        4: q.push_back($urandom_range(0, 1) ? dnv_pkg::CH_DOT : dnv_pkg::CH_HYPHEN);
        default: begin
          // all-digit top label
          q.push_back(dnv_pkg::CH_DOT);
          len = $urandom_range(1, 3);
          for (int i = 0; i < len; i++) q.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
        end
      endcase
    end
    return q;
  endfunction

  // one input beat, held until accepted
  task automatic send_byte(input logic [7:0] c, input logic last);
    int gap;
    gap = draw_wait(in_calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_character <= c;
    in_last_char <= last;
    do @(posedge clk); while (!(in_valid && in_ready));
    board.note_byte(c, last);
    bytes_sent++;
  endtask

  task automatic send_name(input name_t q);
    for (int i = 0; i < q.size(); i++) send_byte(q[i], i == q.size() - 1);
  endtask

  // drain all verdicts, then let the pipeline empty
  task automatic settle();
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic reg_beat(input logic [1:0] idx, input logic [7:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    board.write_reg(idx, data);
  endtask

  task automatic set_limits(input logic [7:0] ml, input logic [7:0] mn, input logic [7:0] mt);
    reg_beat(dnv_pkg::REG_MAX_LABEL, ml);
    reg_beat(dnv_pkg::REG_MAX_NAME, mn);
    reg_beat(dnv_pkg::REG_MIN_TOP, mt);
    reg_beat(REG_NONE, 8'($urandom_range(0, 255)));
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  task automatic random_traffic();
    int stop_at;
    stop_at = bytes_sent + BYTES_PER_SETTING;
    while (bytes_sent < stop_at) send_name(random_name());
    settle();
  endtask

  // result side: random stalls, verdicts checked as they are accepted
  initial begin
    int stall;
    out_ready <= 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      stall = draw_wait(out_calm);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) board.check_verdict(out_name_valid);
  end

  // main sequence
  initial begin
    name_t q;
    board         = new();
    bytes_sent    = 0;
    settings_used = 1;
    in_calm       = 0;
    out_calm      = 0;
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_character <= '0;
    in_last_char <= 1'b0;
    cfg_we       <= 1'b0;
    cfg_index    <= dnv_pkg::REG_MAX_LABEL;
    cfg_data     <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed names at reset limits
    send_name(text("ab.cd"));
    send_name(text("A1-b.Zz9"));
    send_name(text("a"));
    send_name(text("."));
    send_name(text(".ab.cd"));
    send_name(text("ab.cd."));
    send_name(text("abcd"));
    send_name(text("ab..cd"));
    send_name(text("-ab.cd"));
    send_name(text("ab-.cd"));
    send_name(text("ab.cd-"));
    send_name(text("ab.-cd"));
    send_name(text("ab.12"));
    send_name(text("9.99"));
    send_name(text("ab.c"));
    send_name(text("0-9.a-b"));
    send_name(text("a_b.cd"));
    q = text("abx.cd");
    q[2] = 8'h00;
    send_name(q);
    q = text("axb.cxd");
    q[1] = 8'hFF;
    q[5] = 8'h80;
    send_name(q);
    send_name(text({rep("x", 63), ".com"}));
    send_name(text({rep("x", 64), ".com"}));
    send_name(text({rep("x", 63), ".", rep("y", 63), ".", rep("z", 63), ".", rep("w", 61)}));
    send_name(text({rep("x", 63), ".", rep("y", 63), ".", rep("z", 63), ".", rep("w", 62)}));
    // both counters run into saturation
    send_name(text({rep("q", 200), ".", rep("r", 99)}));
    settle();

    // random names across limit settings
    set_limits(8'd63, 8'd253, 8'd2);
    random_traffic();
    set_limits(8'd0, 8'd0, 8'd0);
    random_traffic();
    set_limits(8'hFF, 8'hFF, 8'hFF);
    random_traffic();
    set_limits(8'd1, 8'd1, 8'd1);
    random_traffic();
    set_limits(8'd4, 8'd20, 8'd3);
    random_traffic();
    set_limits(8'($urandom_range(1, 63)), 8'($urandom_range(1, 253)),
               8'($urandom_range(1, 63)));
    random_traffic();
    set_limits(8'd8, 8'd40, 8'd0);
    random_traffic();

    repeat (8) @(posedge clk);
    $display("sent %0d bytes under %0d limit settings", bytes_sent, settings_used);
    $display("checked %0d name verdicts, %0d of them valid", board.names_checked,
             board.names_valid);
    if (board.mismatches == 0) begin
      $display("tb_domain_name_validator: done, clean");
    end else begin
      $display("tb_domain_name_validator: done, errors");
    end
    $finish;
  end

  // watchdog
  initial begin
    #6000000;
    $display("tb_domain_name_validator: done, errors");
    $finish;
  end

endmodule
